/* rtl/fsne_pkg.sv */
// shared types, constants and functions for the fat short name encoder
// no dependencies; imported by every other file of the block

package fsne_pkg;

  localparam int BASE_LEN_DEF = 8;
  localparam int EXT_LEN_DEF  = 3;

  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;
  localparam int BASE_W   = 64;
  localparam int EXT_W    = 24;
  localparam int LEN_W    = 4;
  localparam int BASE_MAX = BASE_W / CHAR_W;
  localparam int EXT_MAX  = EXT_W / CHAR_W;
  localparam int PREFIX_LEN = 4;
  localparam int RC_W     = 3;

  localparam logic [RC_W-1:0] RC_SAT       = 3'd5;
  localparam logic [RC_W-1:0] RC_PREFIX    = 3'd4;
  localparam logic [RC_W-1:0] RC_SHORT_DEV = 3'd3;
  localparam logic [RC_W-1:0] RC_LONG_DEV  = 3'd4;

  localparam logic [CHAR_W-1:0] NUL_CHAR     = 8'h00;
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] DOT_CHAR     = 8'h2E;
  localparam logic [CHAR_W-1:0] DELETED_MARK = 8'hE5;

  localparam logic [31:0] DEV_NUL  = 32'h004C554E;
  localparam logic [31:0] DEV_PRN  = 32'h004E5250;
  localparam logic [31:0] DEV_COM1 = 32'h314D4F43;
  localparam logic [31:0] DEV_COM2 = 32'h324D4F43;
  localparam logic [31:0] DEV_COM3 = 32'h334D4F43;
  localparam logic [31:0] DEV_COM4 = 32'h344D4F43;
  localparam logic [31:0] DEV_LPT1 = 32'h3154504C;
  localparam logic [31:0] DEV_LPT2 = 32'h3254504C;
  localparam logic [31:0] DEV_LPT3 = 32'h3354504C;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_RESERVED = 2'd1,
    ST_INVALID  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_BASE = 2'b01,
    PH_EXT  = 2'b10
  } phase_t;

  typedef struct packed {
    logic              is_valid;
    logic              is_dot;
    logic [CHAR_W-1:0] upper;
  } char_class_t;

  function automatic logic is_reserved(input logic [RC_W-1:0] rc, input logic [31:0] p);
    logic short_hit;
    logic long_hit;
    short_hit = (p == DEV_NUL) || (p == DEV_PRN);
    long_hit  = (p == DEV_COM1) || (p == DEV_COM2) || (p == DEV_COM3) ||
                (p == DEV_COM4) || (p == DEV_LPT1) || (p == DEV_LPT2) ||
                (p == DEV_LPT3);
    return ((rc == RC_SHORT_DEV) && short_hit) || ((rc == RC_LONG_DEV) && long_hit);
  endfunction

endpackage

/* rtl/fsne_in_if.sv */
// input channel: one file name byte per transfer
// depends on fsne_pkg

interface fsne_in_if;
  logic                        valid;
  logic                        ready;
  logic [fsne_pkg::CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

/* rtl/fsne_out_if.sv */
// result channel: packed 8.3 name, length and status per transfer
// depends on fsne_pkg

interface fsne_out_if;
  logic                          valid;
  logic                          ready;
  logic [fsne_pkg::STATUS_W-1:0] status;
  logic [fsne_pkg::BASE_W-1:0]   base_chars;
  logic [fsne_pkg::EXT_W-1:0]    ext_chars;
  logic [fsne_pkg::LEN_W-1:0]    name_length;

  modport source (output valid, output status, output base_chars, output ext_chars,
                  output name_length, input ready);
  modport sink (input valid, input status, input base_chars, input ext_chars,
                input name_length, output ready);
endinterface

/* rtl/fat_short_name_encoder_unit.sv */
// top level of the fat 8.3 short name encoder
// depends on fsne_pkg, fsne_in_if, fsne_out_if and fsne_char_class
//
// One name byte is taken per clock cycle; the name state is updated in the same
// cycle the byte transfers. A zero byte closes the name and its result appears
// in the result register on the next cycle. Nonzero bytes are always accepted;
// a zero byte waits only while the result register still holds a result that
// has not been taken, so a new name can start right behind the previous one.

module fat_short_name_encoder_unit #(
  parameter int BASE_LEN = fsne_pkg::BASE_LEN_DEF,
  parameter int EXT_LEN  = fsne_pkg::EXT_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  fsne_in_if.sink     char_in,
  fsne_out_if.source  result_out
);
  import fsne_pkg::*;

  localparam int BC_W = $clog2(BASE_LEN + 1);
  localparam int EC_W = $clog2(EXT_LEN + 1);

  char_class_t cls;

  phase_t                              phase, phase_next;
  logic [BC_W-1:0]                     base_count, base_count_next;
  logic [EC_W-1:0]                     ext_count, ext_count_next;
  logic [LEN_W-1:0]                    stored_length, stored_length_next;
  logic [BASE_LEN-1:0][CHAR_W-1:0]     base_buffer, base_buffer_next;
  logic [EXT_LEN-1:0][CHAR_W-1:0]      ext_buffer, ext_buffer_next;
  logic                                error_flag, error_flag_next;
  logic [PREFIX_LEN-1:0][CHAR_W-1:0]   reserved_prefix, reserved_prefix_next;
  logic [RC_W-1:0]                     received_count, received_count_next;

  logic                res_valid;
  logic [STATUS_W-1:0] res_status;
  logic [BASE_W-1:0]   res_base;
  logic [EXT_W-1:0]    res_ext;
  logic [LEN_W-1:0]    res_len;

  logic              in_accept;
  logic              end_of_name;
  logic              name_reserved;
  logic [BASE_W-1:0] base_padded;
  logic [EXT_W-1:0]  ext_padded;

  fsne_char_class u_char_class (
    .char_code (char_in.char_code),
    .cls       (cls)
  );

  assign end_of_name   = (char_in.char_code == NUL_CHAR);
  assign char_in.ready = !res_valid || result_out.ready || !end_of_name;
  assign in_accept     = char_in.valid && char_in.ready;
  assign name_reserved = is_reserved(received_count, reserved_prefix);

  for (genvar i = 0; i < BASE_MAX; i++) begin : g_base_pad
    if (i < BASE_LEN) begin : g_used
      assign base_padded[i*CHAR_W +: CHAR_W] = base_buffer[i];
    end else begin : g_pad
      assign base_padded[i*CHAR_W +: CHAR_W] = SPACE_CHAR;
    end
  end

  for (genvar i = 0; i < EXT_MAX; i++) begin : g_ext_pad
    if (i < EXT_LEN) begin : g_used
      assign ext_padded[i*CHAR_W +: CHAR_W] = ext_buffer[i];
    end else begin : g_pad
      assign ext_padded[i*CHAR_W +: CHAR_W] = SPACE_CHAR;
    end
  end

  always_comb begin
    phase_next           = phase;
    base_count_next      = base_count;
    ext_count_next       = ext_count;
    stored_length_next   = stored_length;
    base_buffer_next     = base_buffer;
    ext_buffer_next      = ext_buffer;
    error_flag_next      = error_flag;
    reserved_prefix_next = reserved_prefix;
    received_count_next  = received_count;
    if (in_accept) begin
      if (end_of_name) begin
        phase_next           = PH_BASE;
        base_count_next      = '0;
        ext_count_next       = '0;
        stored_length_next   = '0;
        base_buffer_next     = {BASE_LEN{SPACE_CHAR}};
        ext_buffer_next      = {EXT_LEN{SPACE_CHAR}};
        error_flag_next      = 1'b0;
        reserved_prefix_next = '0;
        received_count_next  = '0;
      end else begin
        if (received_count < RC_PREFIX) begin
          for (int i = 0; i < PREFIX_LEN; i++) begin
            if (received_count[1:0] == 2'(i)) begin
              reserved_prefix_next[i] = cls.upper;
            end
          end
        end
        if (received_count < RC_SAT) begin
          received_count_next = received_count + RC_W'(1);
        end
        if (!error_flag) begin
          case (phase)
            PH_BASE: begin
              if (cls.is_dot) begin
                if (base_count == '0) begin
                  error_flag_next = 1'b1;
                end else begin
                  stored_length_next = stored_length + LEN_W'(1);
                  phase_next         = PH_EXT;
                end
              end else if (!cls.is_valid) begin
                error_flag_next = 1'b1;
              end else if (base_count < BC_W'(BASE_LEN)) begin
                for (int i = 0; i < BASE_LEN; i++) begin
                  if (base_count == BC_W'(i)) begin
                    base_buffer_next[i] = cls.upper;
                  end
                end
                base_count_next    = base_count + BC_W'(1);
                stored_length_next = stored_length + LEN_W'(1);
              end else begin
                // base full: the character spills into the extension
                phase_next         = PH_EXT;
                ext_buffer_next[0] = cls.upper;
                ext_count_next     = EC_W'(1);
                stored_length_next = stored_length + LEN_W'(1);
              end
            end
            PH_EXT: begin
              if (cls.is_valid && (ext_count < EC_W'(EXT_LEN))) begin
                for (int i = 0; i < EXT_LEN; i++) begin
                  if (ext_count == EC_W'(i)) begin
                    ext_buffer_next[i] = cls.upper;
                  end
                end
                ext_count_next     = ext_count + EC_W'(1);
                stored_length_next = stored_length + LEN_W'(1);
              end else begin
                error_flag_next = 1'b1;
              end
            end
            default: begin
              error_flag_next = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_BASE;
      base_count      <= '0;
      ext_count       <= '0;
      stored_length   <= '0;
      base_buffer     <= {BASE_LEN{SPACE_CHAR}};
      ext_buffer      <= {EXT_LEN{SPACE_CHAR}};
      error_flag      <= 1'b0;
      reserved_prefix <= '0;
      received_count  <= '0;
    end else begin
      phase           <= phase_next;
      base_count      <= base_count_next;
      ext_count       <= ext_count_next;
      stored_length   <= stored_length_next;
      base_buffer     <= base_buffer_next;
      ext_buffer      <= ext_buffer_next;
      error_flag      <= error_flag_next;
      reserved_prefix <= reserved_prefix_next;
      received_count  <= received_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_accept && end_of_name) begin
      res_valid <= 1'b1;
    end else if (result_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && end_of_name) begin
      if (name_reserved) begin
        res_status <= ST_RESERVED;
        res_base   <= '0;
        res_ext    <= '0;
        res_len    <= '0;
      end else if (error_flag || (base_count == '0)) begin
        res_status <= ST_INVALID;
        res_base   <= BASE_W'(DELETED_MARK);
        res_ext    <= '0;
        res_len    <= '0;
      end else begin
        res_status <= ST_OK;
        res_base   <= base_padded;
        res_ext    <= ext_padded;
        res_len    <= stored_length;
      end
    end
  end

  assign result_out.valid       = res_valid;
  assign result_out.status      = res_status;
  assign result_out.base_chars  = res_base;
  assign result_out.ext_chars   = res_ext;
  assign result_out.name_length = res_len;

endmodule

/* rtl/fsne_char_class.sv */
// character classifier: legal short name character, dot, upper-case form
// depends on fsne_pkg

module fsne_char_class (
  input  logic [fsne_pkg::CHAR_W-1:0] char_code,
  output fsne_pkg::char_class_t       cls
);
  import fsne_pkg::*;

  logic is_alnum;
  logic is_lower;
  logic is_special;

  assign is_lower = (char_code >= 8'h61) && (char_code <= 8'h7A);
  assign is_alnum = ((char_code >= 8'h30) && (char_code <= 8'h39)) ||
                    ((char_code >= 8'h41) && (char_code <= 8'h5A)) || is_lower;

  always_comb begin
    case (char_code)
      8'h2D, 8'h2B, 8'h3D, 8'h3B, 8'h2C, 8'h26, 8'h24, 8'h25, 8'h5F, 8'h40,
      8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h7E, 8'h27, 8'h60, 8'h21, 8'h23, 8'h28,
      8'h29, 8'h96: is_special = 1'b1;
      default: is_special = 1'b0;
    endcase
  end

  assign cls.is_valid = is_alnum || is_special;
  assign cls.is_dot   = (char_code == DOT_CHAR);
  assign cls.upper    = is_lower ? (char_code - 8'h20) : char_code;

endmodule

/* rtl/fsne_checker.sv */
// port level checks for the fat short name encoder, bound to the top level
// depends on fsne_pkg and fat_short_name_encoder_unit

module fsne_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [fsne_pkg::CHAR_W-1:0]   char_code,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [fsne_pkg::STATUS_W-1:0] status,
  input logic [fsne_pkg::BASE_W-1:0]   base_chars,
  input logic [fsne_pkg::EXT_W-1:0]    ext_chars,
  input logic [fsne_pkg::LEN_W-1:0]    name_length
);
  import fsne_pkg::*;

  logic in_xfer;
  logic out_stall;

  assign in_xfer   = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  a_reset_clears : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_result_held : assert property (@(posedge clk) disable iff (rst)
    out_stall |=> out_valid && $stable(status) && $stable(base_chars))
    else $error("stalled result dropped or changed");

  a_end_gives_result : assert property (@(posedge clk) disable iff (rst)
    in_xfer && (char_code == NUL_CHAR) |=> out_valid)
    else $error("terminating byte gave no result");

  a_no_extra_result : assert property (@(posedge clk) disable iff (rst)
    in_xfer && (char_code != NUL_CHAR) && !out_stall |=> !out_valid)
    else $error("result without terminating byte");

  a_invalid_form : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_INVALID) |->
      (base_chars == BASE_W'(DELETED_MARK)) && (ext_chars == '0) && (name_length == '0))
    else $error("invalid result not in deleted-entry form");

endmodule

bind fat_short_name_encoder_unit fsne_checker u_fsne_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (char_in.valid),
  .in_ready    (char_in.ready),
  .char_code   (char_in.char_code),
  .out_valid   (result_out.valid),
  .out_ready   (result_out.ready),
  .status      (result_out.status),
  .base_chars  (result_out.base_chars),
  .ext_chars   (result_out.ext_chars),
  .name_length (result_out.name_length)
);
